FILE: hw/rtl/linear_probe_symbol_table_assert.svh
// Assertion macros for the linear probe symbol table.
// Used by linear_probe_symbol_table.sv; needs no other file.
`ifndef LINEAR_PROBE_SYMBOL_TABLE_ASSERT_SVH
`define LINEAR_PROBE_SYMBOL_TABLE_ASSERT_SVH

// Same-cycle implication, off during reset
`define LPST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define LPST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lpst_pkg.sv
// Shared types and constants of the linear probe symbol table.
// No dependencies; imported by linear_probe_symbol_table.
`default_nettype none

package lpst_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;
   localparam int HASH_W  = 32;

   typedef enum logic [2:0] {
      ACT_GET            = 3'd0,
      ACT_SET_VALUE      = 3'd1,
      ACT_SET_VALUE_ADDR = 3'd2,
      ACT_SET_ADDR       = 3'd3,
      ACT_CHANGE_ADDR    = 3'd4,
      ACT_KEY_BY_ADDR    = 3'd5
   } act_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } st_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the slot array of the symbol table.
`default_nettype none

module lpst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_symbol_table.sv
// Linear probe symbol table: an open-addressing hash table with a one-write, one-read slot RAM.
// Depends on lpst_pkg, lpst_ram and linear_probe_symbol_table_assert.svh.
`default_nettype none
`include "linear_probe_symbol_table_assert.svh"

// An operation is taken when start is high and busy is low; its one result word
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high and cannot
// be held off. After reset the block sweeps the slot RAM once to clear it, which
// keeps busy high until the sweep ends. Each slot lives in one RAM word (key, value,
// address), read one per cycle with registered read data, so the slot RAM read
// port sets the timing: a keyed operation inspects slots from its hash index up
// until a hit, an empty slot or the whole table, a reverse lookup scans in index
// order from slot zero until an address match or the whole table, and the
// trivial cases (key zero, unused action, reverse lookup of minus one) are
// answered without reading a slot. The result comes out in the cycle after the
// last slot is inspected, and a new operation may start in that same cycle.
module linear_probe_symbol_table
   import lpst_pkg::*;
#(
   parameter int CAPACITY     = 256,
   parameter int ADDRESS_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [2:0]                     req_action,
   input  wire logic [KEY_W-1:0]               req_key_id,
   input  wire logic [HASH_W-1:0]              req_key_hash,
   input  wire logic [VALUE_W-1:0]             req_value_in,
   input  wire logic signed [ADDRESS_BITS-1:0] req_address_in,
   output logic                                rsp_strobe,
   output logic                                rsp_status,
   output logic                                rsp_flag,
   output logic [VALUE_W-1:0]                  rsp_value_out,
   output logic signed [ADDRESS_BITS-1:0]      rsp_address_out,
   output logic [KEY_W-1:0]                    rsp_key_out
);

   localparam int IW = $clog2(CAPACITY);
   localparam logic signed [ADDRESS_BITS-1:0] ADDR_NONE  = ADDRESS_BITS'(-1);
   localparam logic signed [ADDRESS_BITS-1:0] ADDR_LOCAL = ADDRESS_BITS'(-2);
   localparam logic [IW+2:0] LOAD_BOUND = (IW+3)'(3 * CAPACITY);

   typedef struct packed {
      logic [KEY_W-1:0]               key;
      logic [VALUE_W-1:0]             value;
      logic signed [ADDRESS_BITS-1:0] addr;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // control state
   st_type        state_ff, state_in;
   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic [IW-1:0] chk_cnt_ff, chk_cnt_in;
   logic [IW-1:0] entry_count_ff, entry_count_in;
   logic          rsp_strobe_ff, rsp_strobe_in;

   // operation and result payload
   act_type                        op_action_ff;
   logic [KEY_W-1:0]               op_key_ff;
   logic [VALUE_W-1:0]             op_value_ff;
   logic signed [ADDRESS_BITS-1:0] op_addr_ff;
   logic                           rsp_status_ff, rsp_status_in;
   logic                           rsp_flag_ff, rsp_flag_in;
   logic [VALUE_W-1:0]             rsp_value_ff, rsp_value_in;
   logic signed [ADDRESS_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [KEY_W-1:0]               rsp_key_ff, rsp_key_in;

   // slot RAM port
   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   logic [IW-1:0]     ram_raddr;
   slot_type          ram_wslot;
   slot_type          rd_slot;
   logic [SLOT_W-1:0] ram_rdata;

   logic          accept;
   act_type       req_act;
   logic          req_probe;
   logic          req_scan;
   logic [IW-1:0] first_idx;
   logic          last_slot;
   logic          hit;
   logic          empty;
   logic          addr_match;
   logic [IW+2:0] load_next;
   logic          at_limit;

   lpst_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wslot),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_slot = slot_type'(ram_rdata);
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign req_act = act_type'(req_action);

   // classify the incoming word: keyed probe, reverse scan or answered at once
   assign req_probe = (req_action <= 3'(ACT_CHANGE_ADDR)) && (req_key_id != '0);
   assign req_scan  = (req_act == ACT_KEY_BY_ADDR) && (req_address_in != ADDR_NONE);
   assign first_idx = req_probe ? req_key_hash[IW-1:0] : '0;

   // slot checks on the word just read
   assign last_slot  = (chk_cnt_ff == '1);
   assign hit        = (rd_slot.key == op_key_ff);
   assign empty      = (rd_slot.key == '0);
   assign addr_match = (rd_slot.key != '0) && (rd_slot.addr == op_addr_ff);
   assign load_next  = ({3'b000, entry_count_ff} + (IW+3)'(1)) << 2;
   assign at_limit   = (load_next > LOAD_BOUND);

   // state register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         rd_idx_ff      <= '0;
         chk_idx_ff     <= '0;
         chk_cnt_ff     <= '0;
         entry_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         rd_idx_ff      <= rd_idx_in;
         chk_idx_ff     <= chk_idx_in;
         chk_cnt_ff     <= chk_cnt_in;
         entry_count_ff <= entry_count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // hold the accepted word and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_action_ff <= req_act;
         op_key_ff    <= req_key_id;
         op_value_ff  <= req_value_in;
         op_addr_ff   <= req_address_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_key_ff    <= rsp_key_in;
   end

   // next state, RAM access and result
   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      chk_idx_in     = chk_idx_ff;
      chk_cnt_in     = chk_cnt_ff;
      entry_count_in = entry_count_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_flag_in    = rsp_flag_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_key_in     = rsp_key_ff;
      ram_we         = 1'b0;
      ram_waddr      = chk_idx_ff;
      ram_wslot      = rd_slot;
      ram_raddr      = rd_idx_ff;

      unique case (state_ff)
         // sweep every slot to empty after reset
         ST_CLEAR: begin
            ram_we         = 1'b1;
            ram_waddr      = clr_idx_ff;
            ram_wslot.key  = '0;
            ram_wslot.value = '0;
            ram_wslot.addr = ADDR_NONE;
            clr_idx_in     = clr_idx_ff + IW'(1);
            if (clr_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         // take a word; read its first slot or answer at once
         ST_IDLE: begin
            ram_raddr = first_idx;
            if (accept) begin
               if (req_probe || req_scan) begin
                  rd_idx_in  = first_idx + IW'(1);
                  chk_idx_in = first_idx;
                  chk_cnt_in = '0;
                  state_in   = ST_RUN;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_flag_in   = 1'b0;
                  rsp_value_in  = '0;
                  rsp_key_in    = '0;
                  if (req_act == ACT_GET) begin
                     rsp_addr_in = ADDR_NONE;
                  end else if (req_act == ACT_SET_VALUE_ADDR || req_act == ACT_SET_ADDR) begin
                     rsp_addr_in = req_address_in;
                  end else begin
                     rsp_addr_in = '0;
                  end
               end
            end
         end

         // inspect one slot per cycle while the next one is read
         ST_RUN: begin
            ram_raddr  = rd_idx_ff;
            rd_idx_in  = rd_idx_ff + IW'(1);
            chk_idx_in = rd_idx_ff;
            chk_cnt_in = chk_cnt_ff + IW'(1);
            if ((op_action_ff == ACT_KEY_BY_ADDR) ? (addr_match || last_slot)
                                                  : (hit || empty || last_slot)) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = 1'b0;
               rsp_flag_in   = 1'b0;
               rsp_value_in  = '0;
               rsp_addr_in   = '0;
               rsp_key_in    = '0;
               unique case (op_action_ff)
                  ACT_GET: begin
                     if (hit) begin
                        rsp_flag_in  = 1'b1;
                        rsp_value_in = rd_slot.value;
                        rsp_addr_in  = rd_slot.addr[ADDRESS_BITS-1] ? ADDR_LOCAL
                                                                   : rd_slot.addr;
                     end else begin
                        rsp_addr_in = ADDR_NONE;
                     end
                  end
                  ACT_SET_VALUE, ACT_SET_VALUE_ADDR, ACT_SET_ADDR: begin
                     if (op_action_ff != ACT_SET_VALUE) begin
                        rsp_addr_in = op_addr_ff;
                     end
                     if (hit) begin
                        // update in place; never refused
                        ram_we = 1'b1;
                        if (op_action_ff != ACT_SET_ADDR) begin
                           ram_wslot.value = op_value_ff;
                        end
                        if (op_action_ff != ACT_SET_VALUE) begin
                           rsp_addr_in = rd_slot.addr;
                        end
                     end else if (!empty || at_limit) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        // claim the empty slot
                        ram_we        = 1'b1;
                        ram_wslot.key = op_key_ff;
                        if (op_action_ff != ACT_SET_ADDR) begin
                           ram_wslot.value = op_value_ff;
                        end
                        if (op_action_ff != ACT_SET_VALUE) begin
                           ram_wslot.addr = op_addr_ff;
                        end
                        entry_count_in = entry_count_ff + IW'(1);
                        rsp_flag_in    = 1'b1;
                     end
                  end
                  ACT_CHANGE_ADDR: begin
                     if (hit) begin
                        ram_we         = 1'b1;
                        ram_wslot.addr = op_addr_ff;
                        rsp_flag_in    = 1'b1;
                     end
                  end
                  ACT_KEY_BY_ADDR: begin
                     if (addr_match) begin
                        rsp_flag_in = 1'b1;
                        rsp_key_in  = rd_slot.key;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_flag        = rsp_flag_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_address_out = rsp_addr_ff;
   assign rsp_key_out     = rsp_key_ff;

   // a RAM write while probing ends the operation with a result next cycle
   `LPST_ASSERT_NEXT(a_write_then_result, clock, reset, ram_we && (state_ff == ST_RUN), rsp_strobe, "slot write without a result")
   // the entry count never passes the load bound
   `LPST_ASSERT_NOW(a_load_bound, clock, reset, 1'b1, ({3'b000, entry_count_ff} << 2) <= LOAD_BOUND, "entry count above load bound")
   // a refused insert never reports a new key
   `LPST_ASSERT_NOW(a_refuse_no_flag, clock, reset, rsp_strobe && rsp_status, !rsp_flag, "refused insert flagged as new")
   // a keyed probe or a scan always enters the probe state
   `LPST_ASSERT_NEXT(a_probe_runs, clock, reset, accept && (req_probe || req_scan), state_ff == ST_RUN && !rsp_strobe, "probe did not start")

endmodule

`default_nettype wire
